>>> hw/rtl/doa_pkg.sv
// Package for the disk occlusion accumulator: constants, sequencer states, divider request.
`default_nettype none
package doa_pkg;

    localparam int INDEX_BITS_DEF = 16;

    localparam logic [21:0] PI_Q20  = 22'd3294199;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_ADD  = 1'b1;

    // shared divider geometry
    localparam int DEN_W = 42;
    localparam int QUO_W = 33;
    localparam int LO_W  = 33;
    localparam int CNT_W = 6;

    localparam logic [CNT_W-1:0] QBITS_COS   = 6'd18;
    localparam logic [CNT_W-1:0] QBITS_RATIO = 6'd33;

    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem0;
        logic [LO_W-1:0]  lo;
        logic [CNT_W-1:0] cnt;
    } t_div_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIR,
        S_SQ,
        S_SQA,
        S_FAR,
        S_SQRT,
        S_CHKD,
        S_DE,
        S_DEA,
        S_DR,
        S_DRA,
        S_CHKE,
        S_DVE,
        S_DVEW,
        S_DVR,
        S_DVRW,
        S_CP,
        S_CPA,
        S_PI,
        S_PIA,
        S_DVA,
        S_DVAW,
        S_T1,
        S_T1A,
        S_T2,
        S_T2A,
        S_ADD,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

>>> hw/rtl/doa_divider.sv
// Shared restoring divider: one quotient bit per cycle.
`default_nettype none
module doa_divider
    import doa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    output logic                  o_busy,
    output logic [QUO_W-1:0]      o_quot
);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [LO_W-1:0]  r_lo;
    logic [QUO_W-1:0] r_quot;
    logic [CNT_W-1:0] r_cnt;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_lo[LO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= i_req.cnt;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem0;
            r_den  <= i_req.den;
            r_lo   <= i_req.lo;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            // shift in the next dividend bit, subtract where it fits
            r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_lo   <= {r_lo[LO_W-2:0], 1'b0};
            r_quot <= {r_quot[QUO_W-2:0], w_ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

>>> hw/rtl/disk_occlusion_accumulator_top.sv
// Top level of the disk-to-disk ambient occlusion accumulator.
// Sequence: a receiver load frees the input in the cycle after its beat; a culled occluder
//   updates the sum from the skip, distance, length or facing check, a full one after
//   29 square-root steps and 18 + 18 + 33 divider steps; a beat marked last then raises
//   the result beat. Flow: one item at a time; the sequencer, the shared multiplier and
//   the shared divider set the rate.
// Reset: synchronous, active low; clears the receiver, the running sum and the sequencer.
`default_nettype none
module disk_occlusion_accumulator_top
    import doa_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave side
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // patch_index[15:0], pos_x[47:16], pos_y[79:48], pos_z[111:80], nrm_x[127:112],
    // nrm_y[143:128], nrm_z[159:144], disk_area[191:160], prior_occlusion[208:192], zero pad
    input  wire logic [215:0] i_s_tdata,
    // mode[0]
    input  wire logic         i_s_tuser,
    // last
    input  wire logic         i_s_tlast,
    // master side
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // receiver_index[15:0], occlusion[32:16], zero pad
    output logic [39:0]       o_m_tdata
);

    localparam int KEY_W = (INDEX_BITS < 16) ? INDEX_BITS : 16;

    // ---------------------------------------------------------------
    // Input fields
    // ---------------------------------------------------------------
    logic        [15:0] w_patch;
    logic signed [31:0] w_pos [3];
    logic signed [15:0] w_nrm [3];
    logic        [31:0] w_area;
    logic        [16:0] w_prior;
    logic               w_accept;

    assign w_patch  = i_s_tdata[15:0];
    assign w_pos[0] = i_s_tdata[47:16];
    assign w_pos[1] = i_s_tdata[79:48];
    assign w_pos[2] = i_s_tdata[111:80];
    assign w_nrm[0] = i_s_tdata[127:112];
    assign w_nrm[1] = i_s_tdata[143:128];
    assign w_nrm[2] = i_s_tdata[159:144];
    assign w_area   = i_s_tdata[191:160];
    assign w_prior  = i_s_tdata[208:192];
    assign w_accept = i_s_tvalid && o_s_tready;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_state r_state, n_state;
    logic [1:0] r_k;
    logic       r_last;
    logic       r_zero;     // occluder adds nothing

    // receiver disk and running sum
    logic signed [31:0] r_rpos [3];
    logic signed [15:0] r_rnrm [3];
    logic        [31:0] r_rarea;
    logic   [KEY_W-1:0] r_ridx;
    logic signed [47:0] r_sum;

    // occluder disk
    logic signed [31:0] r_opos [3];
    logic signed [15:0] r_onrm [3];
    logic        [31:0] r_oarea;
    logic        [16:0] r_oprior;
    logic               r_oself;

    // datapath
    logic signed [28:0] r_dir [3];
    logic        [57:0] r_dsq;
    logic        [57:0] r_sx;
    logic        [57:0] r_sr;
    logic        [57:0] r_sb;
    logic signed [46:0] r_dote;
    logic signed [46:0] r_dotr;
    logic        [17:0] r_ce;
    logic        [17:0] r_cr;
    logic        [19:0] r_cp;
    logic [DEN_W-1:0]   r_den;
    logic [QUO_W-1:0]   r_ratio;
    logic        [36:0] r_x;
    logic        [21:0] r_t;
    logic signed [69:0] r_prod;

    // ---------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------
    logic signed [32:0] w_diff [3];
    logic        [32:0] w_dmag [3];
    logic               w_skip;
    logic        [38:0] w_lim;
    logic               w_far;
    logic        [57:0] w_sq_trial;
    logic               w_sq_ge;
    logic        [46:0] w_dotr_mag;
    logic        [47:0] w_num;
    logic               w_negr;
    logic signed [48:0] w_term;
    logic signed [48:0] w_nsum;
    logic        [47:0] w_sum_sat;
    logic        [16:0] w_occl;

    logic signed [40:0] w_mul_a;
    logic signed [28:0] w_mul_b;
    logic signed [69:0] w_mul_p;

    t_div_req         w_div_req;
    logic             w_div_busy;
    logic [QUO_W-1:0] w_div_quot;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = 33'(r_rpos[i]) - 33'(r_opos[i]);
            w_dmag[i] = w_diff[i][32] ? 33'(-w_diff[i]) : 33'(w_diff[i]);
        end
    end

    // self, zero area, or a component too far apart to ever count
    assign w_skip = r_oself || (r_oarea == '0) ||
                    (w_dmag[0][32:28] != '0) || (w_dmag[1][32:28] != '0) ||
                    (w_dmag[2][32:28] != '0);

    assign w_lim = {r_oarea, 6'b0} + {1'b0, r_oarea, 5'b0} + {5'b0, r_oarea, 2'b0};
    assign w_far = r_dsq > {3'b0, w_lim, 16'b0};

    assign w_sq_trial = r_sr + r_sb;
    assign w_sq_ge    = r_sx >= w_sq_trial;

    assign w_dotr_mag = r_dotr[46] ? 47'(-r_dotr) : 47'(r_dotr);
    assign w_negr     = r_dotr > 0;

    assign w_term = r_zero ? '0 :
                    (w_negr ? -49'($signed({27'b0, r_t})) : 49'($signed({27'b0, r_t})));
    assign w_nsum = 49'(r_sum) + w_term;
    always_comb begin
        if (w_nsum[48] != w_nsum[47]) begin
            w_sum_sat = w_nsum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end else begin
            w_sum_sat = w_nsum[47:0];
        end
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == MODE_LOAD) begin
                        n_state = i_s_tlast ? S_OUT : S_IDLE;
                    end else begin
                        n_state = S_DIR;
                    end
                end
            end
            S_DIR:  n_state = w_skip ? S_ADD : S_SQ;
            S_SQ:   n_state = S_SQA;
            S_SQA:  n_state = (r_k == 2'd2) ? S_FAR : S_SQ;
            S_FAR:  n_state = w_far ? S_ADD : S_SQRT;
            S_SQRT: n_state = r_sb[0] ? S_CHKD : S_SQRT;
            S_CHKD: n_state = (r_sr[28:0] == '0) ? S_ADD : S_DE;
            S_DE:   n_state = S_DEA;
            S_DEA:  n_state = (r_k == 2'd2) ? S_DR : S_DE;
            S_DR:   n_state = S_DRA;
            S_DRA:  n_state = (r_k == 2'd2) ? S_CHKE : S_DR;
            S_CHKE: n_state = r_dote[46] ? S_ADD : S_DVE;
            S_DVE:  n_state = S_DVEW;
            S_DVEW: n_state = w_div_busy ? S_DVEW : S_DVR;
            S_DVR:  n_state = S_DVRW;
            S_DVRW: n_state = w_div_busy ? S_DVRW : S_CP;
            S_CP:   n_state = S_CPA;
            S_CPA:  n_state = S_PI;
            S_PI:   n_state = S_PIA;
            S_PIA:  n_state = S_DVA;
            S_DVA:  n_state = S_DVAW;
            S_DVAW: n_state = w_div_busy ? S_DVAW : S_T1;
            S_T1:   n_state = S_T1A;
            S_T1A:  n_state = S_T2;
            S_T2:   n_state = S_T2A;
            S_T2A:  n_state = S_ADD;
            S_ADD:  n_state = r_last ? S_OUT : S_IDLE;
            S_OUT:  n_state = i_m_tready ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs, multiplier operands, divider requests
    // ---------------------------------------------------------------
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        w_mul_a    = '0;
        w_mul_b    = '0;
        w_num      = '0;
        w_div_req  = '0;
        case (r_state)
            S_IDLE: o_s_tready = 1'b1;
            S_OUT:  o_m_tvalid = 1'b1;
            S_SQ: begin
                w_mul_a = 41'(r_dir[r_k]);
                w_mul_b = r_dir[r_k];
            end
            S_DE: begin
                w_mul_a = 41'(r_dir[r_k]);
                w_mul_b = 29'(r_onrm[r_k]);
            end
            S_DR: begin
                w_mul_a = 41'(r_dir[r_k]);
                w_mul_b = 29'(r_rnrm[r_k]);
            end
            S_CP: begin
                w_mul_a = $signed({23'b0, r_ce});
                w_mul_b = $signed({11'b0, r_cr});
            end
            S_PI: begin
                w_mul_a = $signed({1'b0, r_dsq[55:16]});
                w_mul_b = $signed({7'b0, PI_Q20});
            end
            S_T1: begin
                w_mul_a = $signed({8'b0, r_ratio});
                w_mul_b = $signed({9'b0, r_cp});
            end
            S_T2: begin
                w_mul_a = $signed({4'b0, r_x});
                w_mul_b = $signed({12'b0, r_oprior});
            end
            S_DVE, S_DVR: begin
                // 2*|dot| / d, quotient known to fit 18 bits
                w_num           = (r_state == S_DVE) ? {r_dote[46:0], 1'b0}
                                                     : {w_dotr_mag, 1'b0};
                w_div_req.start = 1'b1;
                w_div_req.den   = {13'b0, r_sr[28:0]};
                w_div_req.rem0  = {12'b0, w_num[47:18]};
                w_div_req.lo    = {w_num[17:0], 15'b0};
                w_div_req.cnt   = QBITS_COS;
            end
            S_DVA: begin
                // (area << 32) / denom, at most one
                w_div_req.start = 1'b1;
                w_div_req.den   = r_den;
                w_div_req.rem0  = {11'b0, r_oarea[31:1]};
                w_div_req.lo    = {r_oarea[0], 32'b0};
                w_div_req.cnt   = QBITS_RATIO;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    doa_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_busy  (w_div_busy),
        .o_quot  (w_div_quot)
    );

    // ---------------------------------------------------------------
    // Control and receiver state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_rarea <= '0;
            r_ridx  <= '0;
            r_sum   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_rpos[i] <= '0;
                r_rnrm[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_s_tuser == MODE_LOAD)) begin
                        for (int i = 0; i < 3; i++) begin
                            r_rpos[i] <= w_pos[i];
                            r_rnrm[i] <= w_nrm[i];
                        end
                        r_rarea <= w_area;
                        r_ridx  <= w_patch[KEY_W-1:0];
                        r_sum   <= '0;
                    end
                end
                S_DIR:                r_k <= '0;
                S_SQA, S_DEA, S_DRA:  r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 1'b1;
                S_ADD:                r_sum <= $signed(w_sum_sat);
                default:              r_k <= r_k;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Occluder datapath
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_p;
        case (r_state)
            S_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    r_opos[i] <= w_pos[i];
                    r_onrm[i] <= w_nrm[i];
                end
                r_oarea  <= w_area;
                r_oprior <= (w_prior > ONE_Q16) ? ONE_Q16 : w_prior;
                r_oself  <= w_patch[KEY_W-1:0] == r_ridx;
                r_last   <= i_s_tlast;
            end
            S_DIR: begin
                for (int i = 0; i < 3; i++) begin
                    r_dir[i] <= w_diff[i][28:0];
                end
                r_zero <= w_skip;
                r_dsq  <= '0;
                r_dote <= '0;
                r_dotr <= '0;
            end
            S_SQA: r_dsq <= r_dsq + r_prod[57:0];
            S_FAR: begin
                r_zero <= w_far;
                r_sx   <= r_dsq;
                r_sr   <= '0;
                r_sb   <= 58'(1) << 56;
            end
            S_SQRT: begin
                // one result bit a step
                if (w_sq_ge) begin
                    r_sx <= r_sx - w_sq_trial;
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb <= r_sb >> 2;
            end
            S_CHKD: r_zero <= r_sr[28:0] == '0;
            S_DEA:  r_dote <= r_dote + r_prod[46:0];
            S_DRA:  r_dotr <= r_dotr + r_prod[46:0];
            S_CHKE: r_zero <= r_dote[46];
            S_DVEW: r_ce <= w_div_quot[17:0];
            S_DVRW: r_cr <= w_div_quot[17:0];
            S_CPA:  r_cp <= r_prod[35:16];
            S_PIA:  r_den <= r_prod[61:20] + {10'b0, r_oarea};
            S_DVAW: r_ratio <= w_div_quot;
            S_T1A:  r_x <= r_prod[52:16];
            S_T2A:  r_t <= r_prod[53:32];
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Result beat
    // ---------------------------------------------------------------
    always_comb begin
        if ((r_rarea == '0) || (r_sum <= 0)) begin
            w_occl = '0;
        end else if (r_sum > 48'sd65536) begin
            w_occl = ONE_Q16;
        end else begin
            w_occl = r_sum[16:0];
        end
    end

    assign o_m_tdata = {7'b0, w_occl, 16'(r_ridx)};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while a result beat is pending");

    a_occl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[32:16] <= ONE_Q16))
        else $error("occlusion above one");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_busy)
        else $error("divider started while busy");

    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_tuser == MODE_LOAD) && !i_s_tlast) |=> o_s_tready)
        else $error("receiver load did not return to idle");

endmodule
`default_nettype wire
